### sv/lcc_pkg.sv
package lcc_pkg;

	localparam int POS_BITS_DEF = 32;
	localparam int LEN_W        = 31;
	localparam int BNC_W        = 17;
	localparam int NRM_W        = 18;
	localparam int FRAC_W       = 17;

	localparam logic [BNC_W-1:0] ONE_Q16   = BNC_W'(65536);
	localparam logic [LEN_W-1:0] DEPTH_MAX = {LEN_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_CABLE    = 2'd0,
		KIND_HALF_ROD = 2'd1,
		KIND_ROD      = 2'd2
	} kind_t;

	// side info riding along the square root chain
	typedef struct packed {
		logic             valid;
		kind_t            func;
		logic             anchored;
		logic [LEN_W-1:0] len;
		logic [BNC_W-1:0] bounce;
		logic [2:0]       neg;
	} ctl_t;

	// side info riding along the divider chain
	typedef struct packed {
		logic             valid;
		logic [2:0]       neg;
		logic             zero;
		logic [LEN_W-1:0] depth;
		logic [BNC_W-1:0] bounce;
		logic             two_body;
	} res_ctl_t;

endpackage

### sv/lcc_if.sv
interface lcc_link_if #(
	parameter int POS_BITS = lcc_pkg::POS_BITS_DEF
) ();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 func;
	logic                       anchored;
	logic signed [POS_BITS-1:0] first_x;
	logic signed [POS_BITS-1:0] first_y;
	logic signed [POS_BITS-1:0] first_z;
	logic signed [POS_BITS-1:0] second_x;
	logic signed [POS_BITS-1:0] second_y;
	logic signed [POS_BITS-1:0] second_z;
	logic [30:0]                link_length;
	logic [16:0]                bounce;

	modport source (output valid, func, anchored, first_x, first_y, first_z,
		second_x, second_y, second_z, link_length, bounce, input ready);
	modport sink (input valid, func, anchored, first_x, first_y, first_z,
		second_x, second_y, second_z, link_length, bounce, output ready);
endinterface

interface lcc_contact_if ();
	logic               valid;
	logic               ready;
	logic signed [17:0] normal_x;
	logic signed [17:0] normal_y;
	logic signed [17:0] normal_z;
	logic [30:0]        depth;
	logic [16:0]        bounce_out;
	logic               two_body;

	modport source (output valid, normal_x, normal_y, normal_z, depth, bounce_out,
		two_body, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, depth, bounce_out,
		two_body, output ready);
endinterface

### sv/link_constraint_contact_unit.sv
// throughput: one link per cycle; the whole pipe holds while a contact waits
// cost: one square root cell per distance bit, one divide cell per normal fraction bit
// links that make no contact leave a bubble and produce no output transaction
// reset: arst_n clears all valid flags at once, no clearing pass
module link_constraint_contact_unit #(
	parameter int POS_BITS = lcc_pkg::POS_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lcc_link_if.sink             link_in,
	lcc_contact_if.source        contact_out
);
	import lcc_pkg::*;

	// distance width: diffs need one bit more than positions
	localparam int R  = POS_BITS + 1;
	// compare width covers both the distance and the link length
	localparam int CW = ((R > LEN_W) ? R : LEN_W) + 1;

	// global advance: everything moves unless a finished contact is stuck
	logic en;
	logic out_valid_q;
	assign en            = !out_valid_q || contact_out.ready;
	assign link_in.ready = en;

	// stage 1: per axis difference, sign and magnitude
	logic [R-1:0] fst [3];
	logic [R-1:0] snd [3];
	logic [R-1:0] dif [3];
	logic [3*R-1:0] mag_n;
	ctl_t ctl_n;

	assign fst[0] = {link_in.first_x[POS_BITS-1], link_in.first_x};
	assign fst[1] = {link_in.first_y[POS_BITS-1], link_in.first_y};
	assign fst[2] = {link_in.first_z[POS_BITS-1], link_in.first_z};
	assign snd[0] = {link_in.second_x[POS_BITS-1], link_in.second_x};
	assign snd[1] = {link_in.second_y[POS_BITS-1], link_in.second_y};
	assign snd[2] = {link_in.second_z[POS_BITS-1], link_in.second_z};

	always_comb begin
		ctl_n.valid    = link_in.valid;
		ctl_n.func     = kind_t'(link_in.func);
		ctl_n.anchored = link_in.anchored;
		ctl_n.len      = link_in.link_length;
		ctl_n.bounce   = (link_in.bounce > ONE_Q16) ? ONE_Q16 : link_in.bounce;
		for (int k = 0; k < 3; k++) begin
			dif[k] = snd[k] - fst[k];
			ctl_n.neg[k] = dif[k][R-1];
			mag_n[k*R +: R] = dif[k][R-1] ? (~dif[k] + R'(1)) : dif[k];
		end
	end

	ctl_t         ctl_s1, ctl_s2, ctl_s3;
	logic [3*R-1:0] mag_s1, mag_s2, mag_s3;
	logic [2*R-1:0] sq_s2 [3];
	logic [2*R-1:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_n;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// stage 2 squares each magnitude, stage 3 adds them
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_n;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= mag_s1[k*R +: R] * mag_s1[k*R +: R];
			end
			mag_s2 <= mag_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			mag_s3 <= mag_s2;
		end
	end

	// square root chain: one root bit per cell
	ctl_t           sq_ctl  [R+1];
	logic [2*R-1:0] sq_rad  [R+1];
	logic [R+1:0]   sq_rem  [R+1];
	logic [R-1:0]   sq_root [R+1];
	logic [3*R-1:0] sq_mag  [R+1];

	assign sq_ctl[0]  = ctl_s3;
	assign sq_rad[0]  = sum_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_mag[0]  = mag_s3;

	for (genvar i = 0; i < R; i++) begin : g_sqrt
		lcc_sqrt_cell #(.R(R)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (sq_ctl[i]),
			.rad_i  (sq_rad[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.mag_i  (sq_mag[i]),
			.ctl_o  (sq_ctl[i+1]),
			.rad_o  (sq_rad[i+1]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1]),
			.mag_o  (sq_mag[i+1])
		);
	end

	// stage 4: compare distance with link length, pick normal direction
	ctl_t         sc;
	logic [R-1:0] distance;
	logic [CW-1:0] dist_w, len_w, gap;
	logic          hit, toward;
	res_ctl_t      rc_n;

	assign sc       = sq_ctl[R];
	assign distance = sq_root[R];
	assign dist_w   = CW'(distance);
	assign len_w    = CW'(sc.len);

	always_comb begin
		unique case (sc.func)
			KIND_CABLE: begin
				hit    = dist_w >= len_w;
				toward = 1'b1;
			end
			KIND_HALF_ROD: begin
				hit    = dist_w <= len_w;
				toward = 1'b0;
			end
			KIND_ROD: begin
				hit    = dist_w != len_w;
				toward = dist_w > len_w;
			end
			default: begin
				// unused kind: no contact
				hit    = 1'b0;
				toward = 1'b0;
			end
		endcase
		gap            = (dist_w >= len_w) ? (dist_w - len_w) : (len_w - dist_w);
		rc_n.valid     = sc.valid && hit;
		rc_n.neg       = toward ? sc.neg : ~sc.neg;
		rc_n.zero      = distance == '0;
		rc_n.depth     = (gap > CW'(DEPTH_MAX)) ? DEPTH_MAX : gap[LEN_W-1:0];
		rc_n.bounce    = (sc.func == KIND_ROD) ? '0 : sc.bounce;
		rc_n.two_body  = !sc.anchored;
	end

	res_ctl_t dv_ctl  [FRAC_W+1];
	logic [R-1:0]        dv_dist [FRAC_W+1];
	logic [3*R-1:0]      dv_rem  [FRAC_W+1];
	logic [3*FRAC_W-1:0] dv_quo  [FRAC_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_ctl[0] <= '0;
		end else if (en) begin
			dv_ctl[0] <= rc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_dist[0] <= distance;
			dv_rem[0]  <= sq_mag[R];
			dv_quo[0]  <= '0;
		end
	end

	// divider chain: one fraction bit of |d| * 65536 / distance per cell
	for (genvar j = 0; j < FRAC_W; j++) begin : g_div
		lcc_div_cell #(.R(R), .FIRST(j == 0)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (dv_ctl[j]),
			.dist_i (dv_dist[j]),
			.rem_i  (dv_rem[j]),
			.quo_i  (dv_quo[j]),
			.ctl_o  (dv_ctl[j+1]),
			.dist_o (dv_dist[j+1]),
			.rem_o  (dv_rem[j+1]),
			.quo_o  (dv_quo[j+1])
		);
	end

	// output register: apply sign, zero distance gives a zero normal
	res_ctl_t            dc;
	logic [NRM_W-1:0]    nrm_n [3];
	logic [NRM_W-1:0]    nrm_q [3];
	logic [LEN_W-1:0]    depth_q;
	logic [BNC_W-1:0]    bounce_q;
	logic                two_body_q;
	logic [FRAC_W-1:0]   q;

	assign dc = dv_ctl[FRAC_W];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			q        = dc.zero ? '0 : dv_quo[FRAC_W][k*FRAC_W +: FRAC_W];
			nrm_n[k] = dc.neg[k] ? (~NRM_W'(q) + NRM_W'(1)) : NRM_W'(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_q      <= nrm_n;
			depth_q    <= dc.depth;
			bounce_q   <= dc.bounce;
			two_body_q <= dc.two_body;
		end
	end

	assign contact_out.valid      = out_valid_q;
	assign contact_out.normal_x   = nrm_q[0];
	assign contact_out.normal_y   = nrm_q[1];
	assign contact_out.normal_z   = nrm_q[2];
	assign contact_out.depth      = depth_q;
	assign contact_out.bounce_out = bounce_q;
	assign contact_out.two_body   = two_body_q;
endmodule

### sv/lcc_sqrt_cell.sv
module lcc_sqrt_cell #(
	parameter int R = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  lcc_pkg::ctl_t    ctl_i,
	input  logic [2*R-1:0]   rad_i,
	input  logic [R+1:0]     rem_i,
	input  logic [R-1:0]     root_i,
	input  logic [3*R-1:0]   mag_i,
	output lcc_pkg::ctl_t    ctl_o,
	output logic [2*R-1:0]   rad_o,
	output logic [R+1:0]     rem_o,
	output logic [R-1:0]     root_o,
	output logic [3*R-1:0]   mag_o
);
	import lcc_pkg::*;

	logic [R+1:0] rem_sh;
	logic [R+1:0] trial;
	logic         take;

	// one root bit per cell: bring down two radicand bits, try root*4+1
	assign rem_sh = {rem_i[R-1:0], rad_i[2*R-1 -: 2]};
	assign trial  = {root_i, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= {rad_i[2*R-3:0], 2'b00};
			rem_o  <= take ? (rem_sh - trial) : rem_sh;
			root_o <= {root_i[R-2:0], take};
			mag_o  <= mag_i;
		end
	end
endmodule

### sv/lcc_div_cell.sv
module lcc_div_cell #(
	parameter int R     = 33,
	parameter bit FIRST = 1'b0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  lcc_pkg::res_ctl_t                 ctl_i,
	input  logic [R-1:0]                      dist_i,
	input  logic [3*R-1:0]                    rem_i,
	input  logic [3*lcc_pkg::FRAC_W-1:0]      quo_i,
	output lcc_pkg::res_ctl_t                 ctl_o,
	output logic [R-1:0]                      dist_o,
	output logic [3*R-1:0]                    rem_o,
	output logic [3*lcc_pkg::FRAC_W-1:0]      quo_o
);
	import lcc_pkg::*;

	logic [R:0]         rs   [3];
	logic [2:0]         ge;
	logic [3*R-1:0]     rem_n;
	logic [3*FRAC_W-1:0] quo_n;

	// restoring divide step, three axes side by side
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rs[k] = FIRST ? {1'b0, rem_i[k*R +: R]} : {rem_i[k*R +: R], 1'b0};
			ge[k] = rs[k] >= {1'b0, dist_i};
			rem_n[k*R +: R] = ge[k] ? R'(rs[k] - {1'b0, dist_i}) : rs[k][R-1:0];
			quo_n[k*FRAC_W +: FRAC_W] = {quo_i[k*FRAC_W +: FRAC_W-1], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_o <= dist_i;
			rem_o  <= rem_n;
			quo_o  <= quo_n;
		end
	end
endmodule
